// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; they compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: property failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== rtl/dbf_pkg.sv =====
// Types, constants and helper functions of the detection box filter.
`default_nettype none

package dbf_pkg;

  localparam int unsigned MAX_PROPOSALS = 256;
  localparam int unsigned CountLimit    = 256;
  localparam int unsigned CountCapInt   =
      (MAX_PROPOSALS < CountLimit) ? MAX_PROPOSALS : CountLimit;
  localparam logic [8:0]  COUNT_CAP     = 9'(CountCapInt);

  localparam logic [7:0]  MAX_LABEL     = 8'd20;
  localparam logic [13:0] SIZE_LIMIT    = 14'd8192;
  localparam int unsigned FRAC_BITS     = 14;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 21;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_CONF_THRESH   = 3'd2,
    CFG_CLASS_MASK    = 3'd3,
    CFG_TOP_BAND      = 3'd4,
    CFG_BOTTOM_MARGIN = 3'd5
  } cfg_idx_e;

  localparam logic [13:0] RST_FRAME_WIDTH   = 14'd1920;
  localparam logic [13:0] RST_FRAME_HEIGHT  = 14'd1080;
  localparam logic [16:0] RST_CONF_THRESH   = 17'd13107;
  localparam logic [20:0] RST_CLASS_MASK    = 21'd32960;
  localparam logic [15:0] RST_TOP_BAND      = 16'd6554;
  localparam logic [12:0] RST_BOTTOM_MARGIN = 13'd10;

  typedef struct packed {
    logic               terminator;
    logic               last_proposal;
    logic [7:0]         class_label;
    logic [16:0]        score;
    logic signed [15:0] norm_xmin;
    logic signed [15:0] norm_ymin;
    logic signed [15:0] norm_xmax;
    logic signed [15:0] norm_ymax;
  } in_item_t;

  typedef struct packed {
    logic        is_summary;
    logic [7:0]  box_id;
    logic [4:0]  box_class;
    logic [16:0] box_score;
    logic [12:0] box_x;
    logic [12:0] box_y;
    logic [13:0] box_width;
    logic [13:0] box_height;
    logic [8:0]  box_count;
    logic        frame_valid;
    logic        last_result;
  } result_t;

  // Zero acts as one, anything above 8192 acts as 8192.
  function automatic logic [13:0] eff_size(input logic [13:0] s);
    logic [13:0] r;
    r = s;
    if (s == 14'd0) r = 14'd1;
    else if (s > SIZE_LIMIT) r = SIZE_LIMIT;
    return r;
  endfunction

  // Q2.14 coordinate to pixel: scale, truncate, clamp to [0, size-1].
  function automatic logic [12:0] to_pixel(input logic signed [15:0] coord,
                                           input logic [13:0] size);
    logic signed [30:0] prod;
    logic [16:0]        px;
    prod = coord * $signed({1'b0, size});
    px   = prod[30:FRAC_BITS];
    if (prod[30]) px = '0;
    else if (px >= {3'b000, size}) px = {3'b000, size} - 17'd1;
    return px[12:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dbf_if.sv =====
// Valid/ready channel interfaces for proposals and filter results.
`default_nettype none

interface dbf_in_if import dbf_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dbf_out_if import dbf_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/detection_box_filter.sv =====
// A single compute stage between input register and result buffer sets the rate.
// Throughput: one proposal per cycle while the buffer has room; a box-plus-summary
// proposal needs two output beats and holds the input register until the result
// buffer is empty after the pop.
// Reset (rst_ni, async low): empties both stages, clears box count and skip flag,
// loads the configuration registers with their defaults.
`default_nettype none

`include "assert_macros.svh"

module detection_box_filter import dbf_pkg::*; #(
  parameter int unsigned MaxProposals = MAX_PROPOSALS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // channels
  dbf_in_if.sink                     in_i,
  dbf_out_if.source                  out_o
);

  // boxes kept per frame never exceed the 8-bit id range
  localparam logic [8:0] CountCap =
      9'((MaxProposals < CountLimit) ? MaxProposals : CountLimit);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [13:0] frame_width_q, frame_height_q;
  logic [16:0] conf_thresh_q;
  logic [20:0] class_mask_q;
  logic [15:0] top_band_q;
  logic [12:0] bottom_margin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= RST_FRAME_WIDTH;
      frame_height_q  <= RST_FRAME_HEIGHT;
      conf_thresh_q   <= RST_CONF_THRESH;
      class_mask_q    <= RST_CLASS_MASK;
      top_band_q      <= RST_TOP_BAND;
      bottom_margin_q <= RST_BOTTOM_MARGIN;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i[13:0];
        CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_data_i[13:0];
        CFG_CONF_THRESH:   conf_thresh_q   <= cfg_data_i[16:0];
        CFG_CLASS_MASK:    class_mask_q    <= cfg_data_i[20:0];
        CFG_TOP_BAND:      top_band_q      <= cfg_data_i[15:0];
        CFG_BOTTOM_MARGIN: bottom_margin_q <= cfg_data_i[12:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: one proposal beat held for the compute stage
  // ---------------------------------------------------------------------------
  logic     iv_q;
  in_item_t item_q;
  logic     move;     // held proposal retires into the result buffer
  logic     in_fire;

  assign in_i.ready = !iv_q || move;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_i.ready) begin
      iv_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_i.data;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------------
  logic [8:0] acc_q, acc_d;
  logic       skip_q, skip_d;

  // ---------------------------------------------------------------------------
  // Filter: four coordinate multiplies and the band multiply run in parallel
  // ---------------------------------------------------------------------------
  logic [13:0]        w_eff, h_eff;
  logic [12:0]        x0, y0, x1, y1;
  logic [29:0]        band_prod;
  logic [13:0]        band;
  logic signed [14:0] bot_lim;
  logic               pass_score, pass_class, pass_count, pass_geom, pass_zone;
  logic               keep;
  result_t            box_r, summ_r;
  logic [1:0]         n_res;

  always_comb begin
    w_eff = eff_size(frame_width_q);
    h_eff = eff_size(frame_height_q);

    x0 = to_pixel(item_q.norm_xmin, w_eff);
    y0 = to_pixel(item_q.norm_ymin, h_eff);
    x1 = to_pixel(item_q.norm_xmax, w_eff);
    y1 = to_pixel(item_q.norm_ymax, h_eff);

    band_prod = h_eff * top_band_q;
    band      = band_prod[29:16];
    bot_lim   = $signed({1'b0, h_eff}) - $signed({2'b00, bottom_margin_q});

    pass_score = item_q.score >= conf_thresh_q;
    // labels past 20 never pass, whatever the mask holds
    pass_class = (item_q.class_label <= MAX_LABEL) && class_mask_q[item_q.class_label[4:0]];
    pass_count = acc_q < CountCap;
    pass_geom  = (x0 < x1) && (y0 < y1);
    pass_zone  = ({1'b0, y0} >= band) && ($signed({2'b00, y1}) < bot_lim);

    // only a live, non-terminator proposal can yield a box
    keep = !skip_q && !item_q.terminator &&
           pass_score && pass_class && pass_count && pass_geom && pass_zone;

    box_r             = '0;
    box_r.box_id      = acc_q[7:0];
    box_r.box_class   = item_q.class_label[4:0];
    box_r.box_score   = item_q.score;
    box_r.box_x       = x0;
    box_r.box_y       = y0;
    box_r.box_width   = {1'b0, x1} - {1'b0, x0} + 14'd1;
    box_r.box_height  = {1'b0, y1} - {1'b0, y0} + 14'd1;
    box_r.last_result = !item_q.last_proposal;  // summary follows on last slot

    // summary counts the box of this same beat, if there is one
    summ_r             = '0;
    summ_r.is_summary  = 1'b1;
    summ_r.box_count   = acc_q + {8'd0, keep};
    summ_r.frame_valid = summ_r.box_count != 9'd0;
    summ_r.last_result = 1'b1;

    if (skip_q)                 n_res = 2'd0;
    else if (item_q.terminator) n_res = 2'd1;
    else                        n_res = {1'b0, keep} + {1'b0, item_q.last_proposal};
  end

  // ---------------------------------------------------------------------------
  // Result buffer: two entries, head drives the output channel
  // ---------------------------------------------------------------------------
  result_t    ob_q [2];
  result_t    ob_d [2];
  logic [1:0] oc_q, oc_d;
  logic [1:0] oc_pop;
  logic       pop;

  assign out_o.valid = oc_q != 2'd0;
  assign out_o.data  = ob_q[0];
  assign pop         = out_o.valid && out_o.ready;

  always_comb begin
    oc_pop = oc_q - {1'b0, pop};
    // retire only when every result of the beat finds a slot
    move   = iv_q && ((2'd2 - oc_pop) >= n_res);

    ob_d[0] = pop ? ob_q[1] : ob_q[0];
    ob_d[1] = ob_q[1];
    oc_d    = oc_pop;
    if (move) begin
      if (n_res != 2'd0) begin
        ob_d[oc_pop[0]] = keep ? box_r : summ_r;
      end
      if (n_res == 2'd2) begin
        ob_d[1] = summ_r;
      end
      oc_d = oc_pop + n_res;
    end

    acc_d  = acc_q;
    skip_d = skip_q;
    if (move) begin
      if (skip_q) begin
        if (item_q.last_proposal) skip_d = 1'b0;
      end else if (item_q.terminator) begin
        acc_d  = '0;
        skip_d = !item_q.last_proposal;
      end else if (item_q.last_proposal) begin
        acc_d = '0;
      end else if (keep) begin
        acc_d = acc_q + 9'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oc_q   <= 2'd0;
      acc_q  <= '0;
      skip_q <= 1'b0;
    end else begin
      oc_q   <= oc_d;
      acc_q  <= acc_d;
      skip_q <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q[0] <= ob_d[0];
    ob_q[1] <= ob_d[1];
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_NEVER(a_buf_overflow, clk_i, rst_ni, oc_q == 2'd3)
  `ASSERT_PROP(a_count_capped, clk_i, rst_ni, acc_q <= CountCap)
  `ASSERT_PROP(a_skip_clean, clk_i, rst_ni, skip_q |-> (acc_q == 9'd0))
  `ASSERT_PROP(a_two_need_empty, clk_i, rst_ni,
               (move && (n_res == 2'd2)) |-> (oc_pop == 2'd0))

endmodule

`default_nettype wire

// ===== tb/tb_detection_box_filter.sv =====
// Self-checking testbench for detection_box_filter: random and directed proposals against a predictor.
module tb_detection_box_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import dbf_pkg::*;

  // Run shape
  localparam int CYCLE_LIMIT   = 200_000;  // hard stop, far above the slowest clean run
  localparam int SETTLE_CYCLES = 8;        // pipeline depth is 2, give it some slack
  localparam int HOLD_CYCLES   = 400;      // long receiver hold-off
  localparam int HOLD_AT       = 600;      // proposals taken before the hold-off starts
  localparam int HOLD_BACKLOG  = 20;       // beats still queued when the hold-off starts
  localparam int QUIET_FROM    = 1200;     // no idling on either side in this window
  localparam int QUIET_TO      = 1450;
  localparam int ITEM_TARGET   = 1900;
  localparam int IDLE_PCT      = 13;
  localparam int MAX_REPORTS   = 10;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_HI = 3'd7;

  localparam logic [CFG_DATA_W-1:0] ALL_CLASSES = 21'h1F_FFFF;
  localparam int ONE_Q14 = 16384;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  dbf_in_if  in_if ();
  dbf_out_if out_if ();

  detection_box_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and of the frame state.
  // Starts at the reset values of the block.
  // ---------------------------------------------------------------------------
  logic [13:0] cfg_width       = RST_FRAME_WIDTH;
  logic [13:0] cfg_height      = RST_FRAME_HEIGHT;
  logic [16:0] cfg_thresh      = RST_CONF_THRESH;
  logic [20:0] cfg_mask        = RST_CLASS_MASK;
  logic [15:0] cfg_top_band    = RST_TOP_BAND;
  logic [12:0] cfg_bottom_rows = RST_BOTTOM_MARGIN;
  logic [8:0]  boxes_in_frame  = '0;
  bit          skipping        = 1'b0;  // after a terminator, until the last slot

  in_item_t proposals_to_send[$];  // filled by the stimulus, drained by the driver
  result_t  results_due[$];        // predicted beats, oldest first

  int  queued_cnt     = 0;
  int  proposals_taken = 0;
  int  fault_cnt      = 0;
  bit  in_taken       = 1'b0;  // the beat on the input was accepted at the last edge
  bit  sink_hold      = 1'b0;  // receiver hold-off in progress

  // Zero acts as one, anything past 8192 acts as 8192.
  function automatic int clamp_size(input logic [13:0] s);
    if (s == 14'd0) return 1;
    if (s > SIZE_LIMIT) return int'(SIZE_LIMIT);
    return int'(s);
  endfunction

  // Q2.14 to pixel: signed scale, negative to 0, truncate, clamp to size-1.
  function automatic int scale_coord(input logic signed [15:0] c, input int size);
    longint prod;
    longint px;
    prod = longint'(c) * size;
    if (prod < 0) return 0;
    px = prod >>> FRAC_BITS;
    if (px >= size) px = size - 1;
    return int'(px);
  endfunction

  task automatic push_summary();
    result_t s;
    s = '0;
    s.is_summary  = 1'b1;
    s.box_count   = boxes_in_frame;
    s.frame_valid = (boxes_in_frame != 0);
    s.last_result = 1'b1;
    results_due = {results_due, s};
    boxes_in_frame = '0;
  endtask

  // Works out the beats that one accepted proposal must produce.
  task automatic filter_proposal(input in_item_t p);
    result_t r;
    int w, h, x0, y0, x1, y1, band;
    bit kept;
    if (skipping) begin
      if (p.last_proposal) skipping = 1'b0;
      return;
    end
    if (p.terminator) begin
      push_summary();
      skipping = !p.last_proposal;
      return;
    end
    w    = clamp_size(cfg_width);
    h    = clamp_size(cfg_height);
    x0   = scale_coord(p.norm_xmin, w);
    y0   = scale_coord(p.norm_ymin, h);
    x1   = scale_coord(p.norm_xmax, w);
    y1   = scale_coord(p.norm_ymax, h);
    band = (h * int'(cfg_top_band)) >> 16;
    // label check first: the mask has no bit past class 20
    kept = (p.score >= cfg_thresh) && (p.class_label <= MAX_LABEL) &&
           cfg_mask[p.class_label[4:0]] && (boxes_in_frame < COUNT_CAP) &&
           (x0 < x1) && (y0 < y1) && (y0 >= band) &&
           (y1 < h - int'(cfg_bottom_rows));
    if (kept) begin
      r = '0;
      r.box_id      = boxes_in_frame[7:0];
      r.box_class   = p.class_label[4:0];
      r.box_score   = p.score;
      r.box_x       = 13'(x0);
      r.box_y       = 13'(y0);
      r.box_width   = 14'(x1 - x0 + 1);
      r.box_height  = 14'(y1 - y0 + 1);
      r.last_result = !p.last_proposal;  // the summary follows on the last slot
      results_due = {results_due, r};
      boxes_in_frame = boxes_in_frame + 9'd1;
    end
    if (p.last_proposal) push_summary();
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_FRAME_WIDTH:   cfg_width       = val[13:0];
      CFG_FRAME_HEIGHT:  cfg_height      = val[13:0];
      CFG_CONF_THRESH:   cfg_thresh      = val[16:0];
      CFG_CLASS_MASK:    cfg_mask        = val[20:0];
      CFG_TOP_BAND:      cfg_top_band    = val[15:0];
      CFG_BOTTOM_MARGIN: cfg_bottom_rows = val[12:0];
      default: ;  // unmapped index, ignored by the block too
    endcase
  endtask

  function automatic string show(input result_t r);
    return $sformatf({"sum=%0d id=%0d cls=%0d score=%0d x=%0d y=%0d w=%0d h=%0d ",
                      "cnt=%0d fv=%0d last=%0d"},
                     r.is_summary, r.box_id, r.box_class, r.box_score, r.box_x, r.box_y,
                     r.box_width, r.box_height, r.box_count, r.frame_valid,
                     r.last_result);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  function automatic bit quiet_window();
    return proposals_taken >= QUIET_FROM && proposals_taken < QUIET_TO;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: acceptance tracking at the rising edge, driving at the falling one.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        filter_proposal(in_if.data);
        proposals_taken++;
      end
    end
  end

  // A beat stays up until taken; after that the sender may go idle.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (proposals_to_send.size() != 0 &&
          (quiet_window() || $urandom_range(99) >= IDLE_PCT)) begin
        in_if.data  <= proposals_to_send.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random stalls, plus one long hold-off so the block backs up
  // and drops in_if.ready while the sender keeps offering beats.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni || sink_hold) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= quiet_window() || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Starts only with a backlog queued, so the sender keeps pushing into the stall.
  initial begin
    while (!(proposals_taken >= HOLD_AT && proposals_to_send.size() > HOLD_BACKLOG))
      @(posedge clk_i);
    @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  // Every result beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    result_t due;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (results_due.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= MAX_REPORTS)
          $display("unexpected result beat: %s", show(out_if.data));
      end else begin
        due = results_due.pop_front();
        if (out_if.data.is_summary  !== due.is_summary  ||
            out_if.data.box_id      !== due.box_id      ||
            out_if.data.box_class   !== due.box_class   ||
            out_if.data.box_score   !== due.box_score   ||
            out_if.data.box_x       !== due.box_x       ||
            out_if.data.box_y       !== due.box_y       ||
            out_if.data.box_width   !== due.box_width   ||
            out_if.data.box_height  !== due.box_height  ||
            out_if.data.box_count   !== due.box_count   ||
            out_if.data.frame_valid !== due.frame_valid ||
            out_if.data.last_result !== due.last_result) begin
          fault_cnt++;
          if (fault_cnt <= MAX_REPORTS) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", show(due));
            $display("  actual   %s", show(out_if.data));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Registers change only with the block idle; the predictor copy follows at
  // the same edge the block takes the write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Sender pause: nothing left to send and every predicted beat has come back.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (proposals_to_send.size() != 0 || in_if.valid || results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_item(input in_item_t p);
    proposals_to_send = {proposals_to_send, p};
    queued_cnt++;
  endtask

  function automatic in_item_t proposal(input bit term, input bit last, input int label,
                                        input int score, input int x0, input int y0,
                                        input int x1, input int y1);
    in_item_t p;
    p.terminator    = term;
    p.last_proposal = last;
    p.class_label   = 8'(label);
    p.score         = 17'(score);
    p.norm_xmin     = 16'(x0);
    p.norm_ymin     = 16'(y0);
    p.norm_xmax     = 16'(x1);
    p.norm_ymax     = 16'(y1);
    return p;
  endfunction

  function automatic in_item_t random_item();
    in_item_t p;
    p.terminator    = ($urandom_range(7) == 0);
    p.last_proposal = 1'b0;
    p.class_label   = 8'($urandom);
    p.score         = 17'($urandom_range(0, 131071));
    p.norm_xmin     = 16'($urandom);
    p.norm_ymin     = 16'($urandom);
    p.norm_xmax     = 16'($urandom);
    p.norm_ymax     = 16'($urandom);
    return p;
  endfunction

  // Plausible box starting inside the frame and below the top band; clean ones also pass
  // the class and score filters.
  task automatic queue_box(input bit last, input bit clean);
    int x0, y0;
    int label, score;
    label = (clean || $urandom_range(99) < 85) ? $urandom_range(0, MAX_LABEL)
                                               : $urandom_range(MAX_LABEL + 1, 255);
    if (clean || $urandom_range(99) < 80) score = $urandom_range(cfg_thresh, 65536);
    else score = $urandom_range(0, 131071);
    if (clean) score = $urandom_range(cfg_thresh, 131071);
    x0 = $urandom_range(0, 15000);
    y0 = $urandom_range(int'(cfg_top_band) >> 2, 14000);
    queue_item(proposal(1'b0, last, label, score, x0, y0,
                        x0 + $urandom_range(4, 3000), y0 + $urandom_range(4, 2300)));
  endtask

  // One frame of slots; some frames are cut short by a terminator, whose
  // remaining slots the block must skip.
  task automatic queue_frame(input int slots, input bit clean);
    int cut, i;
    bit last;
    in_item_t p;
    cut = (!clean && $urandom_range(9) == 0) ? $urandom_range(0, slots - 1) : -1;
    for (i = 0; i < slots; i++) begin
      last = (i == slots - 1);
      if (i == cut || (!clean && $urandom_range(11) == 0)) begin
        p = random_item();
        if (i == cut) p.terminator = 1'b1;
        p.last_proposal = last;
        queue_item(p);
      end else begin
        queue_box(last, clean);
      end
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(19))
      0:       return 21'(SIZE_LIMIT);
      1:       return 21'($urandom_range(8193, 16383));  // acts as 8192
      2:       return 21'(0);                            // acts as 1
      3:       return 21'($urandom_range(1, 8));
      default: return 21'($urandom_range(16, 4096));
    endcase
  endfunction

  task automatic random_settings();
    write_reg(CFG_FRAME_WIDTH, pick_size());
    write_reg(CFG_FRAME_HEIGHT, pick_size());
    case ($urandom_range(9))
      0:       write_reg(CFG_CONF_THRESH, 21'd0);
      1:       write_reg(CFG_CONF_THRESH, 21'd65536);
      2:       write_reg(CFG_CONF_THRESH, 21'($urandom_range(0, 131071)));
      default: write_reg(CFG_CONF_THRESH, 21'($urandom_range(0, 40000)));
    endcase
    if ($urandom_range(4) == 0) write_reg(CFG_CLASS_MASK, ALL_CLASSES);
    else write_reg(CFG_CLASS_MASK, 21'($urandom | $urandom));
    if ($urandom_range(4) == 0) write_reg(CFG_TOP_BAND, 21'($urandom_range(0, 65535)));
    else write_reg(CFG_TOP_BAND, 21'($urandom_range(0, 13107)));
    if ($urandom_range(4) == 0) write_reg(CFG_BOTTOM_MARGIN, 21'($urandom_range(0, 8191)));
    else write_reg(CFG_BOTTOM_MARGIN, 21'($urandom_range(0, 40)));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase_slots, slots;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_FRAME_WIDTH;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset settings: 1920x1080, band 108 rows, bottom limit row 1070,
    // classes 6, 7 and 15 enabled.
    queue_item(proposal(0, 0, 15, 65536, 4096, 4096, 8192, 8192));     // kept, score 1.0
    queue_item(proposal(0, 0, 7, 13107, 2000, 3000, 6000, 9000));      // score at threshold
    queue_item(proposal(0, 0, 15, 13106, 2000, 3000, 6000, 9000));     // just below
    queue_item(proposal(0, 0, 0, 65536, 2000, 3000, 6000, 9000));      // class masked off
    queue_item(proposal(0, 0, 21, 65536, 2000, 3000, 6000, 9000));     // label past 20
    queue_item(proposal(0, 0, 255, 65536, 2000, 3000, 6000, 9000));
    queue_item(proposal(0, 0, 6, 40000, -32768, 4000, 32767, 12000));  // clamped both sides
    queue_item(proposal(0, 0, 15, 40000, 5000, 4000, 5000, 9000));     // zero width
    queue_item(proposal(0, 0, 15, 40000, 9000, 4000, 5000, 9000));     // reversed
    queue_item(proposal(0, 0, 15, 60000, -100, 4000, -50, 9000));      // both left of frame
    queue_item(proposal(0, 0, 15, 40000, 1000, 1000, 9000, 9000));     // in the top band
    queue_item(proposal(0, 0, 15, 40000, 1000, 4000, 9000, ONE_Q14));  // in bottom margin
    queue_item(proposal(0, 0, 15, 131071, 1000, 4000, 9000, 15000));   // score past 1.0
    queue_item(proposal(0, 1, 7, 50000, 100, 2000, 200, 3000));        // box then summary
    queue_item(proposal(0, 0, 15, 50000, 100, 2000, 200, 3000));
    queue_item(proposal(0, 1, 4, 50000, 100, 2000, 200, 3000));        // summary alone
    queue_item(proposal(1, 0, 15, 50000, 100, 2000, 200, 3000));       // terminator
    queue_item(proposal(0, 0, 15, 50000, 100, 2000, 200, 3000));       // skipped
    queue_item(proposal(1, 0, 15, 50000, 100, 2000, 200, 3000));       // skipped
    queue_item(proposal(0, 1, 15, 50000, 100, 2000, 200, 3000));       // skipped, ends skip
    queue_item(proposal(1, 1, 7, 50000, 100, 2000, 200, 3000));        // terminator on last
    queue_item(proposal(0, 1, 15, 50000, 100, 2000, 200, 3000));       // box and summary
    wait_drained();

    // Largest frame, every filter wide open; junk above the register width.
    write_reg(CFG_FRAME_WIDTH, 21'h1F_E000);     // low 14 bits: 8192
    write_reg(CFG_FRAME_HEIGHT, 21'd16383);      // acts as 8192
    write_reg(CFG_CONF_THRESH, 21'd0);
    write_reg(CFG_CLASS_MASK, ALL_CLASSES);
    write_reg(CFG_TOP_BAND, 21'd0);
    write_reg(CFG_BOTTOM_MARGIN, 21'd0);
    write_reg(UNMAPPED_IDX_LO, 21'd1);
    write_reg(UNMAPPED_IDX_HI, 21'h1F_FFFF);
    queue_item(proposal(0, 0, 21, 65536, 0, 0, 16383, 16383));         // label past 20
    queue_item(proposal(0, 0, 20, 0, 0, 0, 32767, 32767));             // full frame
    queue_item(proposal(0, 0, 0, 0, -32768, -32768, 32767, 32767));
    queue_item(proposal(0, 1, 20, 0, 0, 0, 2, 2));                     // 0..1 px: two px wide
    wait_drained();

    // Degenerate frame: zero sizes act as 1, so every box is empty; also the
    // widest band and bottom margin.
    write_reg(CFG_FRAME_WIDTH, 21'h1F_C000);     // low 14 bits: 0
    write_reg(CFG_FRAME_HEIGHT, 21'd0);
    write_reg(CFG_CONF_THRESH, 21'd65536);
    write_reg(CFG_TOP_BAND, 21'd65535);
    write_reg(CFG_BOTTOM_MARGIN, 21'd8191);
    queue_item(proposal(0, 0, 3, 65536, 0, 0, 32767, 32767));
    queue_item(proposal(0, 1, 3, 65536, -32768, 0, 32767, 16000));
    wait_drained();

    // Box count limit: more clean boxes than the frame can hold.
    write_reg(CFG_FRAME_WIDTH, 21'(SIZE_LIMIT));
    write_reg(CFG_FRAME_HEIGHT, 21'(SIZE_LIMIT));
    write_reg(CFG_CONF_THRESH, 21'd0);
    write_reg(CFG_TOP_BAND, 21'd0);
    write_reg(CFG_BOTTOM_MARGIN, 21'd0);
    queue_frame(int'(COUNT_CAP) + 40, 1'b1);
    wait_drained();

    // Random phases: new settings, then frames of random length; the long
    // hold-off and the quiet window fall somewhere in here.
    while (queued_cnt < ITEM_TARGET) begin
      random_settings();
      phase_slots = $urandom_range(120, 260);
      while (phase_slots > 0) begin
        slots = $urandom_range(1, 16);
        queue_frame(slots, 1'b0);
        phase_slots -= slots;
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_cnt == 0 && results_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dbf_pkg.sv
rtl/dbf_if.sv
rtl/detection_box_filter.sv
tb/tb_detection_box_filter.sv
